FILE: hdl/interval_range_map_unit_macros.svh
// Assertion helpers shared by the interval range map RTL.
`ifndef INTERVAL_RANGE_MAP_UNIT_MACROS_SVH
`define INTERVAL_RANGE_MAP_UNIT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define IRM_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("interval range map check failed");

// Check that a condition implies a consequence in the same cycle.
`define IRM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("interval range map check failed");

`endif

FILE: hdl/irm_pkg.sv
// ----------------------------------------------------------------------------
// irm_pkg
// Shared types and constants of the interval range map.
// ----------------------------------------------------------------------------
`default_nettype none

package irm_pkg;

  localparam int TableEntries = 64;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int CntW         = $clog2(TableEntries + 1);

  localparam logic [1:0] StatusDone  = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  localparam logic CmdLookup = 1'b0;
  localparam logic CmdAssign = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] lookup_key;
    logic signed [31:0] range_begin;
    logic signed [31:0] range_end;
    logic [7:0]         new_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      read_value;
    logic [1:0]      status;
    logic [CntW-1:0] entry_count;
  } out_item_t;

  // One boundary held by a cell.
  typedef struct packed {
    logic               vld;
    logic signed [31:0] key;
    logic [7:0]         val;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_NEXT,
    CELL_TAKE_PREV,
    CELL_TAKE_INS
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SEL,
    ST_DEC,
    ST_SHL,
    ST_INS_HI,
    ST_INS_LO,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/interval_range_map_unit.sv
// ----------------------------------------------------------------------------
// interval_range_map_unit
// Sorted boundary table mapping signed 32-bit keys to 8-bit values, kept in
// a row of shifting cells, with lookup and range assign.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | in_data_i (irm_pkg::in_item_t)
//  out     | output    | out_valid_o/out_ready_i| out_data_o (irm_pkg::out_item_t)
//  cfg     | input     | cfg_we_i               | cfg_wdata_i (default_value)
//
// One transaction at a time. A lookup or an empty range passes through
// ST_CMP, ST_SEL and ST_DEC to ST_DONE, and a refused assign also passes
// ST_SHL; a completed assign stays in ST_SHL while boundaries are removed
// from the table, the cell row shifting one slot per cycle, then passes
// ST_INS_HI and ST_INS_LO. Reset clears all cell valid bits, the count and
// the base override. A stalled output holds the sequencer in its last state until the result is taken.
`default_nettype none

`include "interval_range_map_unit_macros.svh"

module interval_range_map_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire irm_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output irm_pkg::out_item_t out_data_o,
  input  wire logic         cfg_we_i,
  input  wire logic [7:0]   cfg_wdata_i
);

  localparam int N    = irm_pkg::TableEntries;
  localparam int CntW = irm_pkg::CntW;

  irm_pkg::state_e   state_q, state_d;
  irm_pkg::in_item_t req_q;
  logic [7:0]        default_q, base_q;
  logic              base_ovr_q;
  logic [CntW-1:0]   count_q;

  logic [N-1:0]      lt_w, le_w, lt_q, le_q, vld_w;
  irm_pkg::entry_t   ent_w [N];
  irm_pkg::cell_op_e op_w  [N];
  irm_pkg::entry_t   ins_w;

  logic [7:0]        end_val_q, left_val_q, fval_q;
  logic              fexist_q;
  logic [CntW-1:0]   nb_q, le_len_q, rem_q, new_count_q;
  logic              ins_lo_q, ins_hi_q;
  logic [1:0]        status_q;
  logic [7:0]        read_q;
  logic              out_valid_q;
  irm_pkg::out_item_t out_q;

  logic [7:0]        cur_base;
  logic signed [31:0] key_b;
  logic              take_res;

  assign cur_base = base_ovr_q ? base_q : default_q;
  assign key_b    = (req_q.command == irm_pkg::CmdAssign) ? req_q.range_end
                                                          : req_q.lookup_key;
  assign take_res = !out_valid_q || out_ready_i;

  // Row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    irm_pkg::entry_t nxt, prv;
    if (i == N - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = ent_w[i+1];
    end
    if (i == 0) begin : g_first
      assign prv = '0;
    end else begin : g_rest
      assign prv = ent_w[i-1];
    end
    irm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op_w[i]),
      .next_i  (nxt),
      .prev_i  (prv),
      .ins_i   (ins_w),
      .key_a_i (req_q.range_begin),
      .key_b_i (key_b),
      .ent_o   (ent_w[i]),
      .lt_a_o  (lt_w[i]),
      .le_b_o  (le_w[i])
    );
    assign vld_w[i] = ent_w[i].vld;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      irm_pkg::ST_IDLE:   if (in_valid_i) state_d = irm_pkg::ST_CMP;
      irm_pkg::ST_CMP:    state_d = irm_pkg::ST_SEL;
      irm_pkg::ST_SEL:    state_d = irm_pkg::ST_DEC;
      irm_pkg::ST_DEC: begin
        if (req_q.command == irm_pkg::CmdLookup ||
            req_q.range_begin >= req_q.range_end) begin
          state_d = irm_pkg::ST_DONE;
        end else begin
          state_d = irm_pkg::ST_SHL;
        end
      end
      irm_pkg::ST_SHL: begin
        if (status_q != irm_pkg::StatusDone) begin
          state_d = irm_pkg::ST_DONE;
        end else if (rem_q == '0) begin
          state_d = irm_pkg::ST_INS_HI;
        end
      end
      irm_pkg::ST_INS_HI: state_d = irm_pkg::ST_INS_LO;
      irm_pkg::ST_INS_LO: state_d = irm_pkg::ST_DONE;
      irm_pkg::ST_DONE:   if (take_res) state_d = irm_pkg::ST_IDLE;
      default:            state_d = irm_pkg::ST_IDLE;
    endcase
  end

  // Cell operations and input handshake
  always_comb begin
    in_ready_o = 1'b0;
    ins_w      = '0;
    for (int i = 0; i < N; i++) begin
      op_w[i] = irm_pkg::CELL_HOLD;
    end
    unique case (state_q)
      irm_pkg::ST_IDLE: in_ready_o = 1'b1;
      irm_pkg::ST_SHL: begin
        if (status_q == irm_pkg::StatusDone && rem_q != '0) begin
          for (int i = 0; i < N; i++) begin
            if (CntW'(i) >= nb_q) op_w[i] = irm_pkg::CELL_TAKE_NEXT;
          end
        end
      end
      irm_pkg::ST_INS_HI, irm_pkg::ST_INS_LO: begin
        ins_w.vld = 1'b1;
        if (state_q == irm_pkg::ST_INS_HI) begin
          ins_w.key = req_q.range_end;
          ins_w.val = end_val_q;
        end else begin
          ins_w.key = req_q.range_begin;
          ins_w.val = req_q.new_value;
        end
        if ((state_q == irm_pkg::ST_INS_HI && ins_hi_q) ||
            (state_q == irm_pkg::ST_INS_LO && ins_lo_q)) begin
          for (int i = 0; i < N; i++) begin
            if (CntW'(i) > nb_q) begin
              op_w[i] = irm_pkg::CELL_TAKE_PREV;
            end else if (CntW'(i) == nb_q) begin
              op_w[i] = irm_pkg::CELL_TAKE_INS;
            end
          end
        end
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  // Select values and prefix lengths from the registered flags
  logic [7:0]      end_val_c, left_val_c, fval_c;
  logic            fexist_c;
  logic [CntW-1:0] nb_c, le_len_c;
  always_comb begin
    logic lt_n, le_n, le_p;
    end_val_c  = cur_base;
    left_val_c = cur_base;
    fval_c     = '0;
    fexist_c   = 1'b0;
    nb_c       = '0;
    le_len_c   = '0;
    for (int i = 0; i < N; i++) begin
      lt_n = (i == N - 1) ? 1'b0 : lt_q[(i+1) % N];
      le_n = (i == N - 1) ? 1'b0 : le_q[(i+1) % N];
      le_p = (i == 0) ? 1'b1 : le_q[(i+N-1) % N];
      if (lt_q[i] && !lt_n) begin
        left_val_c = left_val_c & '0 | ent_w[i].val;
        nb_c       = nb_c | CntW'(i + 1);
      end
      if (le_q[i] && !le_n) begin
        end_val_c = end_val_c & '0 | ent_w[i].val;
        le_len_c  = le_len_c | CntW'(i + 1);
      end
      if (vld_w[i] && !le_q[i] && le_p) begin
        fval_c   = fval_c | ent_w[i].val;
        fexist_c = 1'b1;
      end
    end
  end

  // Decide the rebuild of the table
  logic            drop_c, at_min_c, ins_lo_c, ins_hi_c;
  logic [CntW:0]   n_c;
  assign at_min_c = (req_q.range_begin == 32'sh8000_0000);
  assign drop_c   = fexist_q && (fval_q == end_val_q);
  assign ins_lo_c = !at_min_c && (req_q.new_value != left_val_q);
  assign ins_hi_c = (end_val_q != req_q.new_value);
  assign n_c = (CntW+1)'(nb_q) + (CntW+1)'(ins_lo_c) + (CntW+1)'(ins_hi_c)
             + (CntW+1)'(count_q) - (CntW+1)'(le_len_q) - (CntW+1)'(drop_c);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= irm_pkg::ST_IDLE;
      default_q   <= '0;
      base_q      <= '0;
      base_ovr_q  <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) default_q <= cfg_wdata_i;
      if (out_ready_i) out_valid_q <= 1'b0;
      if (state_q == irm_pkg::ST_DONE && take_res) begin
        out_valid_q <= 1'b1;
        if (req_q.command == irm_pkg::CmdAssign &&
            status_q == irm_pkg::StatusDone) begin
          count_q <= new_count_q;
          if (at_min_c) begin
            base_q     <= req_q.new_value;
            base_ovr_q <= 1'b1;
          end
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == irm_pkg::ST_IDLE && in_valid_i) req_q <= in_data_i;
    if (state_q == irm_pkg::ST_CMP) begin
      lt_q <= lt_w;
      le_q <= le_w;
    end
    if (state_q == irm_pkg::ST_SEL) begin
      end_val_q  <= end_val_c;
      left_val_q <= left_val_c;
      fval_q     <= fval_c;
      fexist_q   <= fexist_c;
      nb_q       <= nb_c;
      le_len_q   <= le_len_c;
    end
    if (state_q == irm_pkg::ST_DEC) begin
      ins_lo_q    <= ins_lo_c;
      ins_hi_q    <= ins_hi_c;
      rem_q       <= le_len_q + CntW'(drop_c) - nb_q;
      new_count_q <= n_c[CntW-1:0];
      read_q      <= (req_q.command == irm_pkg::CmdLookup) ? end_val_q : 8'd0;
      if (req_q.command == irm_pkg::CmdLookup) begin
        status_q <= irm_pkg::StatusDone;
      end else if (req_q.range_begin >= req_q.range_end) begin
        status_q <= irm_pkg::StatusEmpty;
      end else if (n_c > (CntW+1)'(N)) begin
        status_q <= irm_pkg::StatusFull;
      end else begin
        status_q <= irm_pkg::StatusDone;
      end
    end
    if (state_q == irm_pkg::ST_SHL && rem_q != '0) rem_q <= rem_q - CntW'(1);
    if (state_q == irm_pkg::ST_DONE && take_res) begin
      out_q.read_value  <= read_q;
      out_q.status      <= status_q;
      out_q.entry_count <= (req_q.command == irm_pkg::CmdAssign &&
                            status_q == irm_pkg::StatusDone) ? new_count_q : count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `IRM_ASSERT_ALWAYS(a_count_range, count_q <= CntW'(N))
  `IRM_ASSERT_IMPL(a_valid_prefix, state_q == irm_pkg::ST_IDLE,
    ((vld_w + N'(1)) & vld_w) == '0)
  `IRM_ASSERT_IMPL(a_valid_count, state_q == irm_pkg::ST_IDLE,
    $countones(vld_w) == 32'(count_q))

endmodule

`default_nettype wire

FILE: hdl/irm_cell.sv
// ----------------------------------------------------------------------------
// irm_cell
// One boundary slot of the sorted table: holds an entry, compares it against
// two broadcast keys, takes a neighbor's entry on a shift or the new entry.
// ----------------------------------------------------------------------------
`default_nettype none

module irm_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire irm_pkg::cell_op_e  op_i,
  input  wire irm_pkg::entry_t    next_i,
  input  wire irm_pkg::entry_t    prev_i,
  input  wire irm_pkg::entry_t    ins_i,
  input  wire logic signed [31:0] key_a_i,
  input  wire logic signed [31:0] key_b_i,
  output irm_pkg::entry_t         ent_o,
  output logic                    lt_a_o,
  output logic                    le_b_o
);

  logic               vld_q, vld_d;
  logic signed [31:0] key_q, key_d;
  logic [7:0]         val_q, val_d;

  // Pick the source of the entry to be registered
  always_comb begin
    vld_d = vld_q;
    key_d = key_q;
    val_d = val_q;
    case (op_i)
      irm_pkg::CELL_TAKE_NEXT: begin
        vld_d = next_i.vld;
        key_d = next_i.key;
        val_d = next_i.val;
      end
      irm_pkg::CELL_TAKE_PREV: begin
        vld_d = prev_i.vld;
        key_d = prev_i.key;
        val_d = prev_i.val;
      end
      irm_pkg::CELL_TAKE_INS: begin
        vld_d = ins_i.vld;
        key_d = ins_i.key;
        val_d = ins_i.val;
      end
      default: begin
        vld_d = vld_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  // Compare against the range keys
  assign lt_a_o = vld_q && (key_q < key_a_i);
  assign le_b_o = vld_q && (key_q <= key_b_i);

  assign ent_o = '{vld: vld_q, key: key_q, val: val_q};

endmodule

`default_nettype wire
